@@ design/ffha_pkg.sv @@
// Package with constants, types and state codes for the first-fit heap allocator.
package ffha_pkg;

  localparam int HdrAl      = 24;
  localparam int AlignLg    = 3;
  localparam int AlignBytes = 8;
  localparam int FreeDepth  = 64;
  localparam int TblAw      = 6;
  localparam int CntW       = 7;
  localparam int StoreDepth = 8192;
  localparam int StoreAw    = 13;
  localparam logic [15:0] Len0 = 16'd65512;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFIT   = 3'd1;
  localparam logic [2:0] ST_ALREADY = 3'd2;
  localparam logic [2:0] ST_ZERO    = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  localparam logic ACT_ALLOC = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_A_W1, S_A_W2, S_SD, S_SD_W, S_F_LEN,
    S_F_RD, S_F_CHK, S_F_DEC, S_F_WN, S_F_WP, S_SU, S_SU_W, S_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] len;
  } entry_t;

  typedef struct packed {
    logic              re;
    logic [TblAw-1:0]  raddr;
    logic              we;
    logic [TblAw-1:0]  waddr;
    entry_t            wdata;
  } tbl_req_t;

  typedef struct packed {
    logic               re;
    logic [StoreAw-1:0] raddr;
    logic               we;
    logic [StoreAw-1:0] waddr;
    logic [15:0]        wdata;
  } store_req_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic [15:0] addr;
  } res_t;

endpackage

@@ design/first_fit_heap_allocator_unit.sv @@
// Top level of the first-fit heap allocator: memories, sequencer and result register.
//
//  channel | direction | ports
//  in      | to block  | in_valid, in_stall, in_action, in_request_bytes, in_payload_address
//  out     | from block| out_valid, out_stall, out_status, out_granted_address
//
// One transaction at a time; an allocate scans the free table entries in order and, when a whole
// block leaves the table, moves the entries behind it down.
// A free scans the free table entries and shifts entries on insert or merge.
// The free table memory is accessed one entry per cycle through a registered read port.
// Reset is synchronous and needs no clearing pass; the result register holds under out_stall.
module first_fit_heap_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_request_bytes,
  input  logic [15:0] in_payload_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_granted_address
);
  import ffha_pkg::*;

  tbl_req_t   tbl;
  store_req_t sto;
  entry_t     tbl_q;
  logic [15:0] sto_q;
  res_t       res;
  logic       out_free;
  logic       out_valid_r;
  logic [2:0] out_status_r;
  logic [15:0] out_addr_r;

  assign out_free = !out_valid_r || !out_stall;

  ffha_ram #(.DEPTH(FreeDepth), .AW(TblAw), .DW(32)) u_tbl (
    .clk(clk), .we(tbl.we), .waddr(tbl.waddr), .wdata(tbl.wdata),
    .re(tbl.re), .raddr(tbl.raddr), .rdata(tbl_q)
  );

  ffha_ram #(.DEPTH(StoreDepth), .AW(StoreAw), .DW(16)) u_store (
    .clk(clk), .we(sto.we), .waddr(sto.waddr), .wdata(sto.wdata),
    .re(sto.re), .raddr(sto.raddr), .rdata(sto_q)
  );

  ffha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_request_bytes(in_request_bytes),
    .in_payload_address(in_payload_address), .tbl(tbl), .tbl_q(tbl_q),
    .sto(sto), .sto_q(sto_q), .res(res), .out_free(out_free)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_status_r <= res.status;
      out_addr_r <= res.addr;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_granted_address = out_addr_r;

endmodule

@@ design/ffha_ram.sv @@
// Generic synchronous RAM with one write port and one registered read port.
module ffha_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ffha_ctrl.sv @@
// Sequencer that scans, updates and shifts the free table and the block length store.
module ffha_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [15:0]          in_request_bytes,
  input  logic [15:0]          in_payload_address,
  output ffha_pkg::tbl_req_t   tbl,
  input  ffha_pkg::entry_t     tbl_q,
  output ffha_pkg::store_req_t sto,
  input  logic [15:0]          sto_q,
  output ffha_pkg::res_t       res,
  input  logic                 out_free
);
  import ffha_pkg::*;

  state_t st_r, st_nxt;
  logic [15:0] n_r, hdr_r, blen_r, ast_r, alen_r, ga_r;
  logic [15:0] prev_s_r, prev_l_r, nx_s_r, nx_l_r, lenm_r, newp_r;
  logic [CntW-1:0] i_r, p_r, cnt_r;
  logic hn_r, mn_r, mp_r, t0w_r, s0w_r, trd0_r, srd0_r;
  logic [2:0] stat_r;

  entry_t tq;
  logic [15:0] sq, hdr_in;
  logic [16:0] al;
  logic [17:0] need, nsum;
  logic [15:0] split_s, split_l, lenm, newp;
  logic mn, mp, fits, tight;
  logic accept;

  assign accept = in_valid && !in_stall;
  assign tq     = (trd0_r && !t0w_r) ? '{start: 16'd0, len: Len0} : tbl_q;
  assign sq     = (srd0_r && !s0w_r) ? Len0 : sto_q;
  assign hdr_in = in_payload_address - 16'(HdrAl);
  assign al     = ({1'b0, n_r} + 17'(AlignBytes - 1)) & ~17'(AlignBytes - 1);
  assign need   = 18'(HdrAl) + {1'b0, al} + 18'(AlignBytes);
  assign fits   = n_r <= tq.len;
  assign tight  = {2'b0, tq.len} < need;
  assign split_s = ast_r + 16'(HdrAl) + al[15:0];
  assign split_l = alen_r - 16'(HdrAl) - al[15:0];
  assign nsum   = {2'b0, hdr_r} + 18'(HdrAl) + {2'b0, blen_r};
  assign mn     = hn_r && (nsum == {2'b0, nx_s_r});
  assign lenm   = mn ? (blen_r + 16'(HdrAl) + nx_l_r) : blen_r;
  assign mp     = (p_r != '0) &&
                  ({2'b0, prev_s_r} + 18'(HdrAl) + {2'b0, prev_l_r} == {2'b0, hdr_r});
  assign newp   = prev_l_r + lenm + 16'(HdrAl);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_ALLOC) begin
            st_nxt = (in_request_bytes == '0) ? S_DONE : S_A_RD;
          end else if (in_payload_address < 16'(HdrAl) || hdr_in[AlignLg-1:0] != '0) begin
            st_nxt = S_DONE;
          end else begin
            st_nxt = S_F_LEN;
          end
        end
      end
      S_A_RD:  st_nxt = (i_r >= cnt_r) ? S_DONE : S_A_CHK;
      S_A_CHK: st_nxt = !fits ? S_A_RD : (tight ? S_SD : S_A_W1);
      S_A_W1:  st_nxt = S_A_W2;
      S_A_W2:  st_nxt = S_DONE;
      S_SD:    st_nxt = (i_r + 7'd1 < cnt_r) ? S_SD_W : S_DONE;
      S_SD_W:  st_nxt = S_SD;
      S_F_LEN: st_nxt = S_F_RD;
      S_F_RD:  st_nxt = (i_r >= cnt_r) ? S_F_DEC : S_F_CHK;
      S_F_CHK: st_nxt = (tq.start == hdr_r) ? S_DONE :
                        ((tq.start < hdr_r) ? S_F_RD : S_F_DEC);
      S_F_DEC: begin
        if (mn) st_nxt = S_F_WN;
        else if (mp) st_nxt = S_F_WP;
        else if (cnt_r >= CntW'(FreeDepth)) st_nxt = S_DONE;
        else st_nxt = S_SU;
      end
      S_F_WN:  st_nxt = mp_r ? S_F_WP : S_DONE;
      S_F_WP:  st_nxt = mn_r ? S_SD : S_DONE;
      S_SU:    st_nxt = (i_r > p_r) ? S_SU_W : S_DONE;
      S_SU_W:  st_nxt = S_SU;
      S_DONE:  st_nxt = out_free ? S_IDLE : S_DONE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    tbl = '0;
    sto = '0;
    in_stall = (st_r != S_IDLE);
    res = '{valid: (st_r == S_DONE) && out_free, status: stat_r, addr: ga_r};
    case (st_r)
      S_IDLE: begin
        sto.re = accept && in_action != ACT_ALLOC;
        sto.raddr = hdr_in[15:AlignLg];
      end
      S_A_RD, S_F_RD: begin
        tbl.re = i_r < cnt_r;
        tbl.raddr = i_r[TblAw-1:0];
      end
      S_A_W1: begin
        tbl.we = 1'b1;
        tbl.waddr = i_r[TblAw-1:0];
        tbl.wdata = '{start: split_s, len: split_l};
        sto.we = 1'b1;
        sto.waddr = ast_r[15:AlignLg];
        sto.wdata = al[15:0];
      end
      S_A_W2: begin
        sto.we = 1'b1;
        sto.waddr = split_s[15:AlignLg];
        sto.wdata = split_l;
      end
      S_SD: begin
        tbl.re = i_r + 7'd1 < cnt_r;
        tbl.raddr = 6'(i_r + 7'd1);
      end
      S_SD_W: begin
        tbl.we = 1'b1;
        tbl.waddr = i_r[TblAw-1:0];
        tbl.wdata = tq;
      end
      S_F_WN: begin
        tbl.we = 1'b1;
        tbl.waddr = p_r[TblAw-1:0];
        tbl.wdata = '{start: hdr_r, len: lenm_r};
        sto.we = 1'b1;
        sto.waddr = hdr_r[15:AlignLg];
        sto.wdata = lenm_r;
      end
      S_F_WP: begin
        tbl.we = 1'b1;
        tbl.waddr = 6'(p_r - 7'd1);
        tbl.wdata = '{start: prev_s_r, len: newp_r};
        sto.we = 1'b1;
        sto.waddr = prev_s_r[15:AlignLg];
        sto.wdata = newp_r;
      end
      S_SU: begin
        if (i_r > p_r) begin
          tbl.re = 1'b1;
          tbl.raddr = 6'(i_r - 7'd1);
        end else begin
          tbl.we = 1'b1;
          tbl.waddr = p_r[TblAw-1:0];
          tbl.wdata = '{start: hdr_r, len: blen_r};
        end
      end
      S_SU_W: begin
        tbl.we = 1'b1;
        tbl.waddr = i_r[TblAw-1:0];
        tbl.wdata = tq;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= CntW'(1);
      t0w_r <= 1'b0;
      s0w_r <= 1'b0;
      trd0_r <= 1'b0;
      srd0_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      trd0_r <= tbl.re && tbl.raddr == '0;
      srd0_r <= sto.re && sto.raddr == '0;
      if (tbl.we && tbl.waddr == '0) t0w_r <= 1'b1;
      if (sto.we && sto.waddr == '0) s0w_r <= 1'b1;
      if ((st_r == S_SD) && !(i_r + 7'd1 < cnt_r)) cnt_r <= cnt_r - 7'd1;
      if ((st_r == S_SU) && !(i_r > p_r)) cnt_r <= cnt_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        n_r <= in_request_bytes;
        hdr_r <= hdr_in;
        ga_r <= '0;
        i_r <= '0;
        hn_r <= 1'b0;
        if (in_action == ACT_ALLOC) begin
          stat_r <= (in_request_bytes == '0) ? ST_ZERO : ST_NOFIT;
        end else begin
          stat_r <= ST_NOFIT;
        end
      end
      S_A_CHK: begin
        if (fits) begin
          ast_r <= tq.start;
          alen_r <= tq.len;
          ga_r <= tq.start + 16'(HdrAl);
          stat_r <= ST_OK;
        end else begin
          i_r <= i_r + 7'd1;
        end
      end
      S_SD_W: i_r <= i_r + 7'd1;
      S_F_LEN: blen_r <= sq;
      S_F_RD: begin
        if (i_r >= cnt_r) p_r <= i_r;
      end
      S_F_CHK: begin
        if (tq.start == hdr_r) begin
          stat_r <= ST_ALREADY;
        end else if (tq.start < hdr_r) begin
          prev_s_r <= tq.start;
          prev_l_r <= tq.len;
          i_r <= i_r + 7'd1;
        end else begin
          p_r <= i_r;
          nx_s_r <= tq.start;
          nx_l_r <= tq.len;
          hn_r <= 1'b1;
        end
      end
      S_F_DEC: begin
        mn_r <= mn;
        mp_r <= mp;
        lenm_r <= lenm;
        newp_r <= newp;
        i_r <= mn ? p_r : cnt_r;
        stat_r <= (!mn && !mp && cnt_r >= CntW'(FreeDepth)) ? ST_FULL : ST_OK;
      end
      S_SU_W: i_r <= i_r - 7'd1;
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(FreeDepth)) else $error("free table count overflow");
  a_wr_inside: assert property (@(posedge clk) disable iff (!rst_n)
    tbl.we |-> ({1'b0, tbl.waddr} <= cnt_r)) else $error("table write past end");
  a_res_code: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (res.status <= ST_FULL)) else $error("bad status code");
`endif

endmodule
